@@ hdl/assert_macros.svh @@
// Assertion macros shared by the route feasibility checker modules.
// Needs signals named clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ hdl/evrfc_pkg.sv @@
// Package for the route feasibility checker: widths, codes, FSM state,
// and the command/status structs between controller and datapath.
`default_nettype none

package evrfc_pkg;

  localparam int VAL_W   = 32;
  localparam int RATE_W  = 24;
  localparam int CAP_W   = 31;
  localparam int CFG_A_W = 3;
  localparam int PROD_W  = VAL_W + RATE_W;

  localparam logic [CFG_A_W-1:0] CFG_BATTERY_CAPACITY  = 3'd0;
  localparam logic [CFG_A_W-1:0] CFG_CONSUMPTION_RATE  = 3'd1;
  localparam logic [CFG_A_W-1:0] CFG_RECHARGE_RATE     = 3'd2;
  localparam logic [CFG_A_W-1:0] CFG_WINDOW_TOLERANCE  = 3'd3;
  localparam logic [CFG_A_W-1:0] CFG_BATTERY_TOLERANCE = 3'd4;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_WINDOW  = 2'd1;
  localparam logic [1:0] STS_BATTERY = 2'd2;

  localparam logic [RATE_W-1:0] RATE_ONE = 24'd65536;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BATT,
    S_CHG,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_start;
    logic visit;
    logic step_batt;
    logic step_chg;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic fail;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/ev_route_feasibility_check.sv @@
// Top level of the electric-vehicle route feasibility checker.
// Instantiates evrfc_ctrl and evrfc_dp; uses evrfc_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   in      | in_valid / in_ready  | mode, start and stop fields
//   out     | out_valid / out_ready| arrival, departure, battery, status
//   cfg     | cfg_we               | cfg_index, cfg_data
//
// A start transaction yields no result.
// A visit passes through S_BATT, S_CHG and S_DONE from accept to result register,
// and the next transaction is taken only once back in S_IDLE, so visits do not overlap:
// the shared 32x24 multiplier is used twice in dependent order (consumption, recharge).
// A finished result waits in the output register; the next transaction is
// taken meanwhile, and its result stalls in the last step until room frees.
// Reset is synchronous; after reset visits are dropped until a start.
`default_nettype none

module ev_route_feasibility_check import evrfc_pkg::*; (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire                     in_mode,
  input  wire  [VAL_W-1:0]        in_start_time,
  input  wire  signed [VAL_W-1:0] in_start_battery,
  input  wire  [VAL_W-1:0]        in_prefix_distance,
  input  wire  [VAL_W-1:0]        in_arc_distance,
  input  wire  [VAL_W-1:0]        in_window_open,
  input  wire  [VAL_W-1:0]        in_window_close,
  input  wire  [VAL_W-1:0]        in_service_time,
  input  wire                     in_is_station,
  input  wire                     in_last_stop,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [VAL_W-1:0]        out_arrival_time,
  output logic [VAL_W-1:0]        out_departure_time,
  output logic signed [VAL_W-1:0] out_battery_left,
  output logic [VAL_W-1:0]        out_route_distance,
  output logic [1:0]              out_status,
  output logic                    out_route_end,
  input  wire                     cfg_we,
  input  wire  [CFG_A_W-1:0]      cfg_index,
  input  wire  [VAL_W-1:0]        cfg_data
);

  cmd_t cmd;
  sts_t sts;

  evrfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  evrfc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_start_time      (in_start_time),
    .in_start_battery   (in_start_battery),
    .in_prefix_distance (in_prefix_distance),
    .in_arc_distance    (in_arc_distance),
    .in_window_open     (in_window_open),
    .in_window_close    (in_window_close),
    .in_service_time    (in_service_time),
    .in_is_station      (in_is_station),
    .in_last_stop       (in_last_stop),
    .cmd                (cmd),
    .sts                (sts),
    .out_arrival_time   (out_arrival_time),
    .out_departure_time (out_departure_time),
    .out_battery_left   (out_battery_left),
    .out_route_distance (out_route_distance),
    .out_status         (out_status),
    .out_route_end      (out_route_end)
  );

endmodule

`default_nettype wire

@@ hdl/evrfc_ctrl.sv @@
// Controller FSM for the route feasibility checker: handshakes, step
// sequencing, armed/failed flag. Uses evrfc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module evrfc_ctrl import evrfc_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  input  wire  in_mode,
  output logic out_valid,
  input  wire  out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;
  logic   failed_r, failed_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_mode && !failed_r) begin
          state_nxt = S_BATT;
        end
      end
      S_BATT: state_nxt = S_CHG;
      S_CHG:  state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready       = (state_r == S_IDLE);
    cmd.load_start = accept && !in_mode;
    cmd.visit      = accept && in_mode && !failed_r;
    cmd.step_batt  = (state_r == S_BATT);
    cmd.step_chg   = (state_r == S_CHG);
    cmd.finish     = (state_r == S_DONE) && out_free;
  end

  always_comb begin
    failed_nxt = failed_r;
    priority if (cmd.load_start) begin
      failed_nxt = 1'b0;
    end else if (cmd.finish && sts.fail) begin
      failed_nxt = 1'b1;
    end else begin
      failed_nxt = failed_r;
    end
    out_valid_nxt = out_valid_r;
    priority if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      failed_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      failed_r    <= failed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_IMPL(a_finish_room, cmd.finish, !out_valid_r || out_ready)
  `ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid_r)
  `ASSERT_NEXT(a_failed_drop, accept && in_mode && failed_r, state_r == S_IDLE && failed_r)

endmodule

`default_nettype wire

@@ hdl/evrfc_dp.sv @@
// Datapath for the route feasibility checker: config registers, route
// state, shared multiplier and result registers. Uses evrfc_pkg.
`default_nettype none
`include "assert_macros.svh"

module evrfc_dp import evrfc_pkg::*; (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     cfg_we,
  input  wire  [CFG_A_W-1:0]      cfg_index,
  input  wire  [VAL_W-1:0]        cfg_data,
  input  wire  [VAL_W-1:0]        in_start_time,
  input  wire  signed [VAL_W-1:0] in_start_battery,
  input  wire  [VAL_W-1:0]        in_prefix_distance,
  input  wire  [VAL_W-1:0]        in_arc_distance,
  input  wire  [VAL_W-1:0]        in_window_open,
  input  wire  [VAL_W-1:0]        in_window_close,
  input  wire  [VAL_W-1:0]        in_service_time,
  input  wire                     in_is_station,
  input  wire                     in_last_stop,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  output logic [VAL_W-1:0]        out_arrival_time,
  output logic [VAL_W-1:0]        out_departure_time,
  output logic signed [VAL_W-1:0] out_battery_left,
  output logic [VAL_W-1:0]        out_route_distance,
  output logic [1:0]              out_status,
  output logic                    out_route_end
);

  localparam int PQ_W = PROD_W - 16;

  function automatic logic [VAL_W-1:0] add_sat(input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VAL_W] ? '1 : s[VAL_W-1:0];
  endfunction

  logic [CAP_W-1:0]  cap_r;
  logic [RATE_W-1:0] cons_r;
  logic [RATE_W-1:0] rchg_r;
  logic [VAL_W-1:0]  wtol_r;
  logic [CAP_W-1:0]  btol_r;

  logic [VAL_W-1:0]        clock_r;
  logic signed [VAL_W-1:0] charge_r;
  logic [VAL_W-1:0]        dist_r;

  logic [VAL_W-1:0]        arrival_r;
  logic [VAL_W-1:0]        wclose_r;
  logic [VAL_W-1:0]        service_r;
  logic                    station_r;
  logic                    last_r;
  logic [PROD_W-1:0]       prod_r;
  logic signed [VAL_W-1:0] batt_r;
  logic [VAL_W-1:0]        tsvc_r;
  logic                    wfail_r;
  logic                    bfail_r;
  logic                    need_r;

  logic [VAL_W-1:0]        out_arr_r;
  logic [VAL_W-1:0]        out_dep_r;
  logic signed [VAL_W-1:0] out_batt_r;
  logic [VAL_W-1:0]        out_dist_r;
  logic [1:0]              out_sts_r;
  logic                    out_end_r;

  logic [VAL_W-1:0]        mul_a;
  logic [RATE_W-1:0]       mul_b;
  logic [VAL_W-1:0]        t_arc;
  logic [VAL_W-1:0]        t_arr;
  logic signed [PQ_W+1:0]  bdiff;
  logic signed [VAL_W-1:0] batt_new;
  logic [VAL_W:0]          close_lim;
  logic signed [VAL_W:0]   batt_x;
  logic signed [VAL_W:0]   neg_tol;
  logic signed [VAL_W:0]   cap_x;
  logic [VAL_W:0]          diff;
  logic [PQ_W:0]           dep_sum;
  logic [VAL_W-1:0]        t_chg;
  logic [VAL_W-1:0]        t_fin;
  logic signed [VAL_W-1:0] b_fin;
  logic [1:0]              s_fin;

  // Shared multiplier: arc times consumption at accept, deficit times
  // recharge rate in the charge step.
  always_comb begin
    batt_x = {batt_r[VAL_W-1], batt_r};
    cap_x  = $signed({2'b00, cap_r});
    diff   = cap_x - batt_x;
    if (cmd.step_chg) begin
      mul_a = diff[VAL_W-1:0];
      mul_b = rchg_r;
    end else begin
      mul_a = in_arc_distance;
      mul_b = cons_r;
    end
  end

  always_comb begin
    t_arc = add_sat(clock_r, in_arc_distance);
    t_arr = (t_arc < in_window_open) ? in_window_open : t_arc;
    bdiff = $signed({{(PQ_W-VAL_W+2){charge_r[VAL_W-1]}}, charge_r})
          - $signed({2'b00, prod_r[PROD_W-1:16]});
    if (bdiff[PQ_W+1] && !(&bdiff[PQ_W+1:VAL_W-1])) begin
      batt_new = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      batt_new = bdiff[VAL_W-1:0];
    end
    close_lim = {1'b0, wclose_r} + {1'b0, wtol_r};
    neg_tol   = -$signed({2'b00, btol_r});
  end

  always_comb begin
    dep_sum = {{(PQ_W-VAL_W+1){1'b0}}, tsvc_r} + {1'b0, prod_r[PROD_W-1:16]};
    t_chg   = (|dep_sum[PQ_W:VAL_W]) ? '1 : dep_sum[VAL_W-1:0];
    t_fin   = tsvc_r;
    b_fin   = batt_r;
    s_fin   = STS_OK;
    priority if (wfail_r) begin
      t_fin = arrival_r;
      s_fin = STS_WINDOW;
    end else if (bfail_r) begin
      s_fin = STS_BATTERY;
    end else if (station_r) begin
      t_fin = need_r ? t_chg : tsvc_r;
      b_fin = $signed({1'b0, cap_r});
    end else begin
      s_fin = STS_OK;
    end
  end

  assign sts.fail = wfail_r || bfail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= '0;
      cons_r <= RATE_ONE;
      rchg_r <= RATE_ONE;
      wtol_r <= '0;
      btol_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BATTERY_CAPACITY:  cap_r  <= cfg_data[CAP_W-1:0];
        CFG_CONSUMPTION_RATE:  cons_r <= cfg_data[RATE_W-1:0];
        CFG_RECHARGE_RATE:     rchg_r <= cfg_data[RATE_W-1:0];
        CFG_WINDOW_TOLERANCE:  wtol_r <= cfg_data;
        CFG_BATTERY_TOLERANCE: btol_r <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r  <= '0;
      charge_r <= '0;
      dist_r   <= '0;
    end else if (cmd.load_start) begin
      clock_r  <= in_start_time;
      charge_r <= in_start_battery;
      dist_r   <= in_prefix_distance;
    end else if (cmd.visit) begin
      dist_r <= add_sat(dist_r, in_arc_distance);
    end else if (cmd.finish) begin
      clock_r  <= t_fin;
      charge_r <= b_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.visit || cmd.step_chg) begin
      prod_r <= PROD_W'(mul_a * mul_b);
    end
    if (cmd.visit) begin
      arrival_r <= t_arr;
      wclose_r  <= in_window_close;
      service_r <= in_service_time;
      station_r <= in_is_station;
      last_r    <= in_last_stop;
    end
    if (cmd.step_batt) begin
      batt_r  <= batt_new;
      tsvc_r  <= add_sat(arrival_r, service_r);
      wfail_r <= {1'b0, arrival_r} > close_lim;
    end
    if (cmd.step_chg) begin
      bfail_r <= batt_x < neg_tol;
      need_r  <= batt_x < cap_x;
    end
    if (cmd.finish) begin
      out_arr_r  <= arrival_r;
      out_dep_r  <= t_fin;
      out_batt_r <= b_fin;
      out_dist_r <= dist_r;
      out_sts_r  <= s_fin;
      out_end_r  <= last_r || wfail_r || bfail_r;
    end
  end

  assign out_arrival_time   = out_arr_r;
  assign out_departure_time = out_dep_r;
  assign out_battery_left   = out_batt_r;
  assign out_route_distance = out_dist_r;
  assign out_status         = out_sts_r;
  assign out_route_end      = out_end_r;

  `ASSERT_NEXT(a_fail_ends, cmd.finish && sts.fail, out_end_r && out_sts_r != STS_OK)

endmodule

`default_nettype wire

@@ sim/ev_route_feasibility_check_tb.sv @@
// Self-checking testbench for ev_route_feasibility_check: directed routes, then random
// routes under several register settings, checked against a stop-by-stop predictor.
// Depends on evrfc_pkg and the ev_route_feasibility_check RTL.
module ev_route_feasibility_check_tb;
  import evrfc_pkg::*;

  localparam bit MODE_START = 1'b0;
  localparam bit MODE_VISIT = 1'b1;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [63:0] VALUE_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam longint BATT_MIN = -64'sd2147483648;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 230;

  typedef struct {
    bit                 mode;
    logic [31:0]        start_time;
    logic signed [31:0] start_battery;
    logic [31:0]        prefix_distance;
    logic [31:0]        arc_distance;
    logic [31:0]        window_open;
    logic [31:0]        window_close;
    logic [31:0]        service_time;
    bit                 is_station;
    bit                 last_stop;
    int                 gap;
  } route_item_t;

  typedef struct packed {
    logic [31:0] arrival_time;
    logic [31:0] departure_time;
    logic [31:0] battery_left;
    logic [31:0] route_distance;
    logic [1:0]  status;
    logic        route_end;
  } stop_report_t;

  typedef struct {
    logic [31:0] clock_now;
    longint      charge;
    logic [31:0] distance;
    bit          failed;
  } route_state_t;

  typedef struct {
    logic [30:0] cap;
    logic [23:0] cons;
    logic [23:0] rech;
    logic [31:0] wtol;
    logic [30:0] btol;
  } checker_cfg_t;

  localparam route_state_t STATE_AT_RESET = '{32'd0, 0, 32'd0, 1'b1};
  localparam checker_cfg_t CFG_AT_RESET = '{31'd0, RATE_ONE, RATE_ONE, 32'd0, 31'd0};

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_mode = 1'b0;
  logic [VAL_W-1:0]         in_start_time = '0;
  logic signed [VAL_W-1:0]  in_start_battery = '0;
  logic [VAL_W-1:0]         in_prefix_distance = '0;
  logic [VAL_W-1:0]         in_arc_distance = '0;
  logic [VAL_W-1:0]         in_window_open = '0;
  logic [VAL_W-1:0]         in_window_close = '0;
  logic [VAL_W-1:0]         in_service_time = '0;
  logic                     in_is_station = 1'b0;
  logic                     in_last_stop = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [VAL_W-1:0]         out_arrival_time;
  logic [VAL_W-1:0]         out_departure_time;
  logic signed [VAL_W-1:0]  out_battery_left;
  logic [VAL_W-1:0]         out_route_distance;
  logic [1:0]               out_status;
  logic                     out_route_end;
  logic                     cfg_we = 1'b0;
  logic [CFG_A_W-1:0]       cfg_index = '0;
  logic [VAL_W-1:0]         cfg_data = '0;

  route_item_t  pending_items[$];
  stop_report_t expected_reports[$];
  route_state_t model_state = STATE_AT_RESET;
  route_state_t plan_state = STATE_AT_RESET;
  checker_cfg_t cfg_model = CFG_AT_RESET;
  route_item_t  on_wire;
  stop_report_t fresh_report;
  stop_report_t due;
  bit           fresh_made;
  bit           calm_phase = 1'b0;
  int           gap_count = 0;
  int           ready_hold = 0;
  int           results_seen = 0;
  int           fail_count = 0;
  int           planned = 0;
  int           cycle_count = 0;

  ev_route_feasibility_check DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_start_time      (in_start_time),
    .in_start_battery   (in_start_battery),
    .in_prefix_distance (in_prefix_distance),
    .in_arc_distance    (in_arc_distance),
    .in_window_open     (in_window_open),
    .in_window_close    (in_window_close),
    .in_service_time    (in_service_time),
    .in_is_station      (in_is_station),
    .in_last_stop       (in_last_stop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_arrival_time   (out_arrival_time),
    .out_departure_time (out_departure_time),
    .out_battery_left   (out_battery_left),
    .out_route_distance (out_route_distance),
    .out_status         (out_status),
    .out_route_end      (out_route_end),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s > VALUE_MAX) ? VALUE_MAX : s;
  endfunction

  function automatic logic [63:0] scale_q16(logic [63:0] a, logic [63:0] r);
    return (a * r) >> 16;
  endfunction

  task automatic advance_route(inout route_state_t s, input route_item_t it,
                               output bit made, output stop_report_t r);
    logic [63:0] t;
    logic [63:0] arrive;
    logic [63:0] used;
    longint      batt;
    longint      cap;
    logic [1:0]  sts;
    made = 1'b0;
    r = '0;
    if (it.mode == MODE_START) begin
      s.clock_now = it.start_time;
      s.charge = it.start_battery;
      s.distance = it.prefix_distance;
      s.failed = 1'b0;
    end else if (!s.failed) begin
      used = scale_q16(it.arc_distance, cfg_model.cons);
      if (longint'(used) >= s.charge - BATT_MIN) batt = BATT_MIN;
      else batt = s.charge - longint'(used);
      s.distance = 32'(sat_add(s.distance, it.arc_distance));
      t = sat_add(s.clock_now, it.arc_distance);
      if (t < it.window_open) t = it.window_open;
      arrive = t;
      sts = STS_OK;
      if (t > ({32'd0, it.window_close} + {32'd0, cfg_model.wtol})) begin
        sts = STS_WINDOW;
      end else begin
        t = sat_add(t, it.service_time);
        if (batt < -longint'(cfg_model.btol)) begin
          sts = STS_BATTERY;
        end else if (it.is_station) begin
          cap = longint'(cfg_model.cap);
          if (batt < cap) t = sat_add(t, scale_q16(cap - batt, cfg_model.rech));
          batt = cap;
        end
      end
      s.clock_now = 32'(t);
      s.charge = batt;
      if (sts != STS_OK) s.failed = 1'b1;
      made = 1'b1;
      r.arrival_time = 32'(arrive);
      r.departure_time = 32'(t);
      r.battery_left = 32'(batt);
      r.route_distance = s.distance;
      r.status = sts;
      r.route_end = it.last_stop || (sts != STS_OK);
    end
  endtask

  // Driver: present the oldest pending transaction after its gap, predict on accept.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_count = 0;
      model_state = STATE_AT_RESET;
      cfg_model = CFG_AT_RESET;
    end else begin
      if (in_valid && in_ready) begin
        advance_route(model_state, on_wire, fresh_made, fresh_report);
        if (fresh_made) expected_reports.push_back(fresh_report);
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && gap_count >= pending_items[0].gap) begin
          on_wire = pending_items.pop_front();
          gap_count = 0;
          in_valid <= 1'b1;
          in_mode <= on_wire.mode;
          in_start_time <= on_wire.start_time;
          in_start_battery <= on_wire.start_battery;
          in_prefix_distance <= on_wire.prefix_distance;
          in_arc_distance <= on_wire.arc_distance;
          in_window_open <= on_wire.window_open;
          in_window_close <= on_wire.window_close;
          in_service_time <= on_wire.service_time;
          in_is_station <= on_wire.is_station;
          in_last_stop <= on_wire.last_stop;
        end else begin
          if (pending_items.size() != 0) gap_count++;
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", field, want, got);
      fail_count++;
    end
  endtask

  // Monitor: check each result, then hold off ready for a random, long or no stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_reports.size() == 0) begin
          $error("result with none pending: arrival %h", out_arrival_time);
          fail_count++;
        end else begin
          due = expected_reports.pop_front();
          compare_field("arrival_time", due.arrival_time, out_arrival_time);
          compare_field("departure_time", due.departure_time, out_departure_time);
          compare_field("battery_left", due.battery_left, out_battery_left);
          compare_field("route_distance", due.route_distance, out_route_distance);
          compare_field("status", 32'(due.status), 32'(out_status));
          compare_field("route_end", 32'(due.route_end), 32'(out_route_end));
        end
        if (results_seen == 150 || results_seen == 600) ready_hold = 300;
        else ready_hold = calm_phase ? 0 : $urandom_range(0, 7);
      end else if (ready_hold > 0) begin
        ready_hold--;
      end
      out_ready <= (ready_hold == 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ev_route_feasibility_check_tb: done, errors");
      $finish;
    end
  end

  function automatic route_item_t start_item(logic [31:0] t0, logic [31:0] b0,
                                             logic [31:0] d0);
    route_item_t it;
    it = '{default: '0};
    it.mode = MODE_START;
    it.start_time = t0;
    it.start_battery = b0;
    it.prefix_distance = d0;
    return it;
  endfunction

  function automatic route_item_t stop_item(logic [31:0] arc, logic [31:0] wo,
                                            logic [31:0] wc, logic [31:0] svc,
                                            bit station, bit last);
    route_item_t it;
    it = '{default: '0};
    it.mode = MODE_VISIT;
    it.arc_distance = arc;
    it.window_open = wo;
    it.window_close = wc;
    it.service_time = svc;
    it.is_station = station;
    it.last_stop = last;
    return it;
  endfunction

  function automatic route_item_t noise_item();
    route_item_t it;
    it.mode = $urandom_range(0, 1);
    it.start_time = $urandom;
    it.start_battery = $urandom;
    it.prefix_distance = $urandom;
    it.arc_distance = $urandom;
    it.window_open = $urandom;
    it.window_close = $urandom;
    it.service_time = $urandom;
    it.is_station = $urandom_range(0, 1);
    it.last_stop = $urandom_range(0, 1);
    it.gap = 0;
    return it;
  endfunction

  function automatic route_item_t random_start();
    route_item_t it;
    it = noise_item();
    it.mode = MODE_START;
    it.start_time = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 500 * ONE);
    if ($urandom_range(0, 9) != 0) it.start_battery = $urandom_range(0, cfg_model.cap);
    if ($urandom_range(0, 9) != 0) it.prefix_distance = $urandom_range(0, 1000 * ONE);
    return it;
  endfunction

  // Place the window around the arrival the route will actually reach.
  function automatic route_item_t random_stop(bit last);
    route_item_t it;
    logic [63:0] pre;
    logic [63:0] arrive;
    logic [63:0] shift;
    int          pick;
    it = noise_item();
    it.mode = MODE_VISIT;
    if ($urandom_range(0, 29) != 0) it.arc_distance = $urandom_range(0, 16 * ONE);
    pre = sat_add(plan_state.clock_now, it.arc_distance);
    shift = $urandom_range(0, 20 * ONE);
    if ($urandom_range(0, 1)) it.window_open = 32'(sat_add(pre, shift));
    else it.window_open = (pre > shift) ? 32'(pre - shift) : 32'd0;
    arrive = (pre > it.window_open) ? pre : it.window_open;
    pick = $urandom_range(0, 15);
    if (pick == 0)
      it.window_close = (arrive >= cfg_model.wtol) ? 32'(arrive - cfg_model.wtol) : 32'd0;
    else if (pick == 1)
      it.window_close = (arrive > 8 * ONE) ? 32'(arrive - $urandom_range(1, 8 * ONE)) : 32'd0;
    else
      it.window_close = 32'(sat_add(arrive, $urandom_range(0, 40 * ONE)));
    it.service_time = $urandom_range(0, 4 * ONE);
    it.is_station = ($urandom_range(0, 3) == 0);
    it.last_stop = last;
    return it;
  endfunction

  task automatic queue_item(route_item_t it);
    bit           ignored;
    bit           made;
    stop_report_t r;
    ignored = (it.mode == MODE_VISIT) && plan_state.failed;
    advance_route(plan_state, it, made, r);
    it.gap = calm_phase ? 0 : $urandom_range(0, 7);
    pending_items.push_back(it);
    if (!ignored) planned++;
  endtask

  task automatic plan_route_piece();
    int stops;
    if ($urandom_range(0, 9) < 8) begin
      queue_item(random_start());
      stops = $urandom_range(1, 12);
      for (int k = 0; k < stops; k++)
        queue_item(random_stop(k == stops - 1 && $urandom_range(0, 3) != 0));
    end else begin
      queue_item(noise_item());
    end
  endtask

  task automatic put_reg(logic [CFG_A_W-1:0] index, logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
  endtask

  task automatic apply_config(logic [31:0] cap, logic [31:0] cons, logic [31:0] rech,
                              logic [31:0] wtol, logic [31:0] btol);
    put_reg(CFG_BATTERY_CAPACITY, cap);
    put_reg(CFG_CONSUMPTION_RATE, cons);
    put_reg(CFG_RECHARGE_RATE, rech);
    put_reg(CFG_WINDOW_TOLERANCE, wtol);
    put_reg(CFG_BATTERY_TOLERANCE, btol);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_model.cap = cap[30:0];
    cfg_model.cons = cons[23:0];
    cfg_model.rech = rech[23:0];
    cfg_model.wtol = wtol;
    cfg_model.btol = btol[30:0];
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    plan_state = model_state;
    queue_item(stop_item(ONE, 0, '1, 0, 0, 0));
    queue_item(start_item(5 * ONE, 10 * ONE, 0));
    queue_item(stop_item(2 * ONE, 0, '1, 0, 1, 1));
    wait_idle();

    apply_config(100 * ONE, 32'h0000_8000, 32'h0002_0000, ONE, 2 * ONE);
    @(negedge clk);
    plan_state = model_state;
    queue_item(start_item(0, 50 * ONE, 0));
    queue_item(stop_item(10 * ONE, 0, 100 * ONE, ONE, 0, 0));
    queue_item(stop_item(5 * ONE, 50 * ONE, 100 * ONE, 0, 1, 0));
    queue_item(stop_item(0, 0, '1, 0, 0, 1));
    queue_item(stop_item(ONE, 0, '1, 0, 1, 0));
    queue_item(start_item(1000 * ONE, 32'h7FFF_FFFF, 32'hFFFF_FF00));
    queue_item(stop_item(ONE, 0, '1, ONE, 1, 0));
    queue_item(stop_item(10 * ONE, 0, 0, 0, 0, 0));
    queue_item(stop_item(ONE, 0, '1, 0, 0, 0));
    queue_item(start_item(32'hFFFF_0000, 32'h8000_0000, 0));
    queue_item(stop_item('1, 0, '1, '1, 1, 0));
    queue_item(stop_item(0, 0, '1, 0, 0, 1));
    queue_item(start_item(10 * ONE, ONE, 0));
    queue_item(stop_item(4 * ONE, 0, '1, 0, 1, 0));
    queue_item(start_item(10 * ONE, 0, 0));
    queue_item(stop_item(0, 0, 9 * ONE, 0, 0, 0));
    queue_item(start_item(10 * ONE, 0, 0));
    queue_item(stop_item(0, 0, 9 * ONE - 1, 0, 0, 0));
    queue_item(start_item(0, 32'hFFFE_0000, 0));
    queue_item(stop_item(0, 0, '1, 0, 0, 0));
    queue_item(stop_item(32'd4, 0, '1, 0, 0, 1));
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: apply_config('1, '1, '1, '1, '1);
        3: apply_config(0, 0, 0, 0, 0);
        4: apply_config($urandom, $urandom, $urandom, $urandom, $urandom);
        default: begin
          apply_config($urandom_range(20 * ONE, 200 * ONE), $urandom_range(32'h4000, 32'h30000),
                       $urandom_range(32'h4000, 32'h30000), $urandom_range(0, 5 * ONE),
                       $urandom_range(0, 10 * ONE));
        end
      endcase
      @(negedge clk);
      calm_phase = (phase == 2);
      plan_state = model_state;
      planned = 0;
      while (planned < PHASE_ITEMS) plan_route_piece();
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("ev_route_feasibility_check_tb: done, clean");
    end else begin
      $display("ev_route_feasibility_check_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/evrfc_pkg.sv
hdl/evrfc_ctrl.sv
hdl/evrfc_dp.sv
hdl/ev_route_feasibility_check.sv
sim/ev_route_feasibility_check_tb.sv
